@@ design/ctlex_pkg.sv @@
// ============================================================================
// ctlex_pkg: shared types and constants of the calculator token lexer
// Lexer modes, token kinds, the result record and character codes.
// ============================================================================
package ctlex_pkg;

  // Token length cap and position counter width
  localparam int MAX_TOKEN_LEN = 255;
  localparam int POS_BITS      = 16;
  localparam logic [7:0] LEN_CAP = 8'((MAX_TOKEN_LEN > 255) ? 255 : MAX_TOKEN_LEN);

  // Result queue depth; three slots must be free before a character is lexed
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);
  localparam int MAX_RES   = 3;

  // Character codes
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Lexer modes
  typedef enum logic [3:0] {
    MODE_IDLE, MODE_IDENT, MODE_RESERVED, MODE_SYMWAIT,
    MODE_DOT, MODE_ZERO, MODE_DIGIT, MODE_HEXX, MODE_HEX, MODE_BINB, MODE_BIN,
    MODE_FLOAT, MODE_E, MODE_EPM, MODE_EXP
  } mode_t;

  // Token kinds
  typedef enum logic [3:0] {
    KIND_DEC     = 4'd0,
    KIND_HEX     = 4'd1,
    KIND_BIN     = 4'd2,
    KIND_FLOAT   = 4'd3,
    KIND_IDENT   = 4'd4,
    KIND_RESV    = 4'd5,
    KIND_SYMBOL  = 4'd6,
    KIND_END     = 4'd7,
    KIND_BADNUM  = 4'd8,
    KIND_BADSYM  = 4'd9
  } kind_t;

  // One token record
  typedef struct packed {
    kind_t       kind;
    logic [15:0] start;
    logic [7:0]  length;
    logic [7:0]  lead;
    logic        last;
  } rec_t;

  // Records produced by one lexed character
  typedef struct packed {
    logic [1:0]           cnt;
    rec_t [MAX_RES-1:0]   recs;
  } push_t;

  // Low 16 bits of a position, zero-extended when the counter is narrower
  function automatic logic [15:0] pos_to_start(logic [POS_BITS-1:0] p);
    logic [POS_BITS+15:0] ext;
    ext = {16'b0, p};
    return ext[15:0];
  endfunction

endpackage

@@ design/ctlex_lexer.sv @@
// ============================================================================
// ctlex_lexer: character stage and lexer state
// Holds one character in an input register and lexes it in a single pass,
// producing up to three token records for the result queue.
// ============================================================================
module ctlex_lexer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_char_code,
  input  logic                in_end_of_text,
  input  logic                push_ok,
  output ctlex_pkg::push_t    push
);
  import ctlex_pkg::*;

  // Input register
  logic       stg_v_r, stg_v_nxt;
  logic [7:0] stg_char_r;
  logic       stg_eot_r;

  // Lexer state
  mode_t                mode_r, mode_nxt;
  logic [7:0]           pend_r, pend_nxt;
  logic [POS_BITS-1:0]  start_r, start_nxt;
  logic [7:0]           len_r, len_nxt;
  logic [POS_BITS-1:0]  pos_r, pos_nxt;

  logic go;

  // Character classes
  function automatic logic is_dig(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    return is_dig(c) || ((lc >= 8'h61) && (lc <= 8'h66));
  endfunction

  function automatic logic is_num_mode(mode_t m);
    return (m >= MODE_DOT) && (m <= MODE_EXP);
  endfunction

  // Number DFA step; MODE_IDLE means the character ends the literal
  function automatic mode_t number_next(mode_t m, logic [7:0] c);
    logic [7:0] lc;
    mode_t      n;
    lc = c | 8'h20;
    n  = MODE_IDLE;
    unique case (m)
      MODE_DOT, MODE_FLOAT: begin
        if (lc == CH_E) n = MODE_E;
        else if (is_dig(c)) n = MODE_FLOAT;
      end
      MODE_ZERO: begin
        if (c == CH_DOT) n = MODE_DOT;
        else if (lc == CH_E) n = MODE_E;
        else if (lc == CH_B) n = MODE_BINB;
        else if (lc == CH_X) n = MODE_HEXX;
        else if (is_dig(c)) n = MODE_DIGIT;
      end
      MODE_DIGIT: begin
        if (c == CH_DOT) n = MODE_DOT;
        else if (lc == CH_E) n = MODE_E;
        else if (is_dig(c)) n = MODE_DIGIT;
      end
      MODE_HEXX, MODE_HEX: begin
        if (is_hex(c)) n = MODE_HEX;
      end
      MODE_BINB, MODE_BIN: begin
        if ((c == CH_ZERO) || (c == CH_ONE)) n = MODE_BIN;
      end
      MODE_E: begin
        if (is_dig(c)) n = MODE_EXP;
        else if ((c == CH_PLUS) || (c == CH_MINUS)) n = MODE_EPM;
      end
      MODE_EPM, MODE_EXP: begin
        if (is_dig(c)) n = MODE_EXP;
      end
      default: n = MODE_IDLE;
    endcase
    return n;
  endfunction

  // Kind given when the open token closes
  function automatic kind_t close_kind(mode_t m);
    kind_t k;
    unique case (m)
      MODE_IDENT:             k = KIND_IDENT;
      MODE_RESERVED:          k = KIND_RESV;
      MODE_SYMWAIT:           k = KIND_SYMBOL;
      MODE_ZERO, MODE_DIGIT:  k = KIND_DEC;
      MODE_HEX:               k = KIND_HEX;
      MODE_BIN:               k = KIND_BIN;
      MODE_FLOAT, MODE_EXP:   k = KIND_FLOAT;
      default:                k = KIND_BADNUM;
    endcase
    return k;
  endfunction

  function automatic logic is_open(mode_t m);
    return m != MODE_IDLE;
  endfunction

  function automatic logic pairs_with(logic [7:0] lead, logic [7:0] c);
    logic p;
    unique case (lead)
      CH_AMP, CH_STAR, CH_SLASH, CH_BAR: p = (c == lead);
      CH_LT, CH_EQ, CH_GT:               p = (c == CH_EQ);
      default:                           p = 1'b0;
    endcase
    return p;
  endfunction

  // Handshake: the stage drains when the queue has room for a full burst
  assign go       = stg_v_r && push_ok;
  assign in_ready = !stg_v_r || push_ok;

  always_comb begin
    stg_v_nxt = stg_v_r;
    if (go) stg_v_nxt = 1'b0;
    if (in_valid && in_ready) stg_v_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_char_r <= in_char_code;
      stg_eot_r  <= in_end_of_text;
    end
  end

  // Single-pass lex of the staged character
  logic [7:0]          c;
  logic [7:0]          grown;
  logic                cls_v, fresh_go, fresh_v, ecls_v;
  rec_t                cls_rec, fresh_rec, ecls_rec, end_rec;
  mode_t               mid_mode, num_n;
  logic [7:0]          mid_pend, mid_len;
  logic [POS_BITS-1:0] mid_start, pos_inc;
  logic [3:0]          cand_v;
  rec_t [3:0]          cand;
  rec_t [MAX_RES-1:0]  slot;
  logic [1:0]          n;

  always_comb begin
    c         = stg_char_r;
    grown     = (len_r < LEN_CAP) ? len_r + 8'd1 : len_r;
    pos_inc   = pos_r + POS_BITS'(1);
    num_n     = number_next(mode_r, c);
    cls_v     = 1'b0;
    fresh_go  = 1'b0;
    fresh_v   = 1'b0;
    mid_mode  = mode_r;
    mid_pend  = pend_r;
    mid_len   = len_r;
    mid_start = start_r;

    cls_rec.kind   = close_kind(mode_r);
    cls_rec.start  = pos_to_start(start_r);
    cls_rec.length = (mode_r == MODE_SYMWAIT) ? 8'd1 : len_r;
    cls_rec.lead   = pend_r;
    cls_rec.last   = 1'b0;

    // Continue or close the open token
    if ((mode_r == MODE_IDENT) || (mode_r == MODE_RESERVED)) begin
      if (is_alpha(c) || is_dig(c) || (c == CH_UNDER)) begin
        mid_len = grown;
      end else begin
        cls_v    = 1'b1;
        fresh_go = 1'b1;
      end
    end else if (mode_r == MODE_SYMWAIT) begin
      cls_v = 1'b1;
      if (pairs_with(pend_r, c)) begin
        cls_rec.length = 8'd2;
        mid_mode       = MODE_IDLE;
        mid_len        = 8'd0;
      end else begin
        fresh_go = 1'b1;
      end
    end else if (is_num_mode(mode_r)) begin
      if (num_n != MODE_IDLE) begin
        mid_mode = num_n;
        mid_len  = grown;
      end else begin
        cls_v    = 1'b1;
        fresh_go = 1'b1;
      end
    end else begin
      fresh_go = 1'b1;
    end

    // Fresh lex of the character
    fresh_rec.kind   = KIND_BADSYM;
    fresh_rec.start  = pos_to_start(pos_r);
    fresh_rec.length = 8'd1;
    fresh_rec.lead   = c;
    fresh_rec.last   = 1'b0;
    if (fresh_go) begin
      mid_mode = MODE_IDLE;
      mid_len  = 8'd0;
      if (is_space(c)) begin
        mid_mode = MODE_IDLE;
      end else if (is_dig(c) || (c == CH_BSL) || is_alpha(c) || (c == CH_UNDER) ||
                   (c == CH_AMP) || (c == CH_STAR) || (c == CH_SLASH) ||
                   (c == CH_LT) || (c == CH_EQ) || (c == CH_GT) || (c == CH_BAR)) begin
        priority if (is_dig(c))
          mid_mode = (c == CH_ZERO) ? MODE_ZERO : MODE_DIGIT;
        else if (c == CH_BSL)
          mid_mode = MODE_RESERVED;
        else if (is_alpha(c) || (c == CH_UNDER))
          mid_mode = MODE_IDENT;
        else
          mid_mode = MODE_SYMWAIT;
        mid_start = pos_r;
        mid_len   = 8'd1;
        mid_pend  = c;
      end else begin
        fresh_v = 1'b1;
        if ((c == CH_BANG) || (c == CH_PCT) || (c == CH_PLUS) || (c == CH_COMMA) ||
            (c == CH_MINUS) || (c == CH_SEMI) || (c == CH_CARET) ||
            (c == CH_LBRC) || (c == CH_RBRC)) begin
          fresh_rec.kind = KIND_SYMBOL;
        end
      end
    end

    // End of text: close what is open, then the end token
    ecls_v          = stg_eot_r && is_open(mid_mode);
    ecls_rec.kind   = close_kind(mid_mode);
    ecls_rec.start  = pos_to_start(mid_start);
    ecls_rec.length = (mid_mode == MODE_SYMWAIT) ? 8'd1 : mid_len;
    ecls_rec.lead   = mid_pend;
    ecls_rec.last   = 1'b0;
    end_rec.kind    = KIND_END;
    end_rec.start   = pos_to_start(pos_inc);
    end_rec.length  = 8'd0;
    end_rec.lead    = 8'd0;
    end_rec.last    = 1'b0;

    // Pack valid records in text order
    cand_v = {stg_eot_r, ecls_v, fresh_v, cls_v};
    cand   = {end_rec, ecls_rec, fresh_rec, cls_rec};
    slot   = '0;
    n      = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i] && (n != 2'd3)) begin
        slot[n] = cand[i];
        n       = n + 2'd1;
      end
    end
    if (n != 2'd0) slot[n - 2'd1].last = 1'b1;

    push.cnt  = go ? n : 2'd0;
    push.recs = slot;

    // Next state
    if (stg_eot_r) begin
      mode_nxt  = MODE_IDLE;
      pend_nxt  = 8'd0;
      start_nxt = '0;
      len_nxt   = 8'd0;
      pos_nxt   = '0;
    end else begin
      mode_nxt  = mid_mode;
      pend_nxt  = mid_pend;
      start_nxt = mid_start;
      len_nxt   = mid_len;
      pos_nxt   = pos_inc;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pend_r  <= 8'd0;
      start_r <= '0;
      len_r   <= 8'd0;
      pos_r   <= '0;
    end else if (go) begin
      mode_r  <= mode_nxt;
      pend_r  <= pend_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

@@ design/ctlex_res_queue.sv @@
// ============================================================================
// ctlex_res_queue: token record queue
// Takes up to three records per cycle and hands them out one per request.
// ============================================================================
module ctlex_res_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  ctlex_pkg::push_t  push,
  output logic              push_ok,
  output logic              out_valid,
  input  logic              out_ready,
  output ctlex_pkg::rec_t   head
);
  import ctlex_pkg::*;

  rec_t                 mem [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RES_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RES_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 pop;

  // Room for a full burst of records
  assign push_ok   = cnt_r <= RES_CNT_W'(RES_DEPTH - MAX_RES);
  assign out_valid = cnt_r != '0;
  assign pop       = out_valid && out_ready;
  assign head      = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RES_PTR_W'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + RES_PTR_W'(pop);
    cnt_nxt    = cnt_r + RES_CNT_W'(push.cnt) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Burst write at consecutive slots
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < push.cnt) mem[wr_ptr_r + RES_PTR_W'(i)] <= push.recs[i];
    end
  end

endmodule

@@ design/calculator_token_lexer_top.sv @@
// ============================================================================
// calculator_token_lexer_top: streaming calculator expression lexer
// One character per request in; token records (kind, start, length, lead
// character, last-of-run flag) out, zero to three per character.
// ----------------------------------------------------------------------------
// Channel | Ports                                        | Dir
// in      | in_valid/in_ready, in_char_code, in_end_of_text | input
// out     | out_valid/out_ready, out_token_kind, out_token_start,
//         | out_token_length, out_lead_char, out_last_of_run | output
//
// One character per cycle while the queue has room: a staged character is
// lexed in one pass and its records enter a four-entry queue. The stage
// advances while the queue holds at most one record, so a character giving
// two or three tokens can stall the input. Records are registered in the queue.
// Reset (synchronous, rst_n low) empties stage and queue and returns to idle.
// A stalled output keeps its record; input flows while the queue holds at
// most one record.
// ============================================================================
module calculator_token_lexer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_token_kind,
  output logic [15:0] out_token_start,
  output logic [7:0]  out_token_length,
  output logic [7:0]  out_lead_char,
  output logic        out_last_of_run
);
  import ctlex_pkg::*;

  push_t push;
  logic  push_ok;
  rec_t  head;

  ctlex_lexer u_lexer (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_code   (in_char_code),
    .in_end_of_text (in_end_of_text),
    .push_ok        (push_ok),
    .push           (push)
  );

  ctlex_res_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_ok   (push_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_token_kind   = head.kind;
  assign out_token_start  = head.start;
  assign out_token_length = head.length;
  assign out_lead_char    = head.lead;
  assign out_last_of_run  = head.last;

endmodule

@@ design/ctlex_checker.sv @@
// ============================================================================
// ctlex_checker: port-level checks of the lexer
// Output stall behavior, input stall cause and the shape of emitted token
// records.
// ============================================================================
module ctlex_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_token_kind,
  input logic [15:0] out_token_start,
  input logic [7:0]  out_token_length,
  input logic [7:0]  out_lead_char,
  input logic        out_last_of_run
);
  import ctlex_pkg::*;

  // Stalled record holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_kind) &&
    $stable(out_token_start) && $stable(out_token_length) && $stable(out_lead_char))
    else $error("stalled token record changed");

  // Input stalls only behind queued records
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with nothing to send");

  // Only defined kinds leave the block
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_token_kind <= KIND_BADSYM)
    else $error("undefined token kind");

  // End token closes the run and carries no text
  a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_kind == KIND_END) |->
    out_last_of_run && (out_token_length == 8'd0) && (out_lead_char == 8'd0))
    else $error("malformed end token");

  // Symbols span one or two characters
  a_sym_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_kind == KIND_SYMBOL) |->
    (out_token_length == 8'd1) || (out_token_length == 8'd2))
    else $error("bad symbol length");

endmodule

bind calculator_token_lexer_top ctlex_checker u_ctlex_checker (.*);

@@ test/calculator_token_lexer_top_test.sv @@
// ============================================================================
// calculator_token_lexer_top_test: self-checking bench for the token lexer
// Feeds character texts through the request channel, predicts the token
// records of each accepted character and compares every record that leaves
// the block, field by field, in order. Covers all number forms, bad numbers,
// words, symbols, odd bytes, back-to-back traffic, output back-pressure and
// random texts.
// ============================================================================
module calculator_token_lexer_top_test;
  import ctlex_pkg::*;

  localparam int LIMIT_CYCLES = 20000;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_CHARS = 6;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_char_code = 8'h00;
  logic        in_end_of_text = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_token_kind;
  logic [15:0] out_token_start;
  logic [7:0]  out_token_length;
  logic [7:0]  out_lead_char;
  logic        out_last_of_run;

  calculator_token_lexer_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_code     (in_char_code),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_lead_char    (out_lead_char),
    .out_last_of_run  (out_last_of_run)
  );

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle rates in percent, hold-off requests for the receiver
  int tx_idle_pct = 12;
  int rx_idle_pct = 12;
  int hold_asked = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // Lexer state of the predictor
  mode_t               lx_mode = MODE_IDLE;
  logic [7:0]          lx_lead = 8'h00;
  logic [POS_BITS-1:0] lx_start = '0;
  logic [7:0]          lx_len = 8'h00;
  logic [POS_BITS-1:0] lx_pos = '0;

  rec_t       char_tokens[$];     // tokens of the character being lexed
  rec_t       expected_tokens[$]; // tokens still to come out of the block
  logic [7:0] text_q[$];          // text being assembled for sending
  int         mismatches = 0;
  int         tokens_seen = 0;

  // --------------------------------------------------------------------------
  // Token predictor
  // --------------------------------------------------------------------------
  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_hex(logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    return is_digit(c) || (lc >= "a" && lc <= "f");
  endfunction

  // Number DFA; MODE_IDLE means the character ends the literal
  function automatic mode_t next_num_mode(mode_t m, logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    case (m)
      MODE_DOT, MODE_FLOAT: return (lc == CH_E) ? MODE_E :
                                   is_digit(c) ? MODE_FLOAT : MODE_IDLE;
      MODE_ZERO, MODE_DIGIT: begin
        if (c == CH_DOT) return MODE_DOT;
        if (lc == CH_E) return MODE_E;
        if (m == MODE_ZERO && lc == CH_B) return MODE_BINB;
        if (m == MODE_ZERO && lc == CH_X) return MODE_HEXX;
        return is_digit(c) ? MODE_DIGIT : MODE_IDLE;
      end
      MODE_HEXX, MODE_HEX: return is_hex(c) ? MODE_HEX : MODE_IDLE;
      MODE_BINB, MODE_BIN: return (c == CH_ZERO || c == CH_ONE) ? MODE_BIN : MODE_IDLE;
      MODE_E: begin
        if (is_digit(c)) return MODE_EXP;
        return (c == CH_PLUS || c == CH_MINUS) ? MODE_EPM : MODE_IDLE;
      end
      MODE_EPM, MODE_EXP: return is_digit(c) ? MODE_EXP : MODE_IDLE;
      default: return MODE_IDLE;
    endcase
  endfunction

  function automatic kind_t num_kind(mode_t m);
    case (m)
      MODE_ZERO, MODE_DIGIT: return KIND_DEC;
      MODE_HEX:              return KIND_HEX;
      MODE_BIN:              return KIND_BIN;
      MODE_FLOAT, MODE_EXP:  return KIND_FLOAT;
      default:               return KIND_BADNUM;
    endcase
  endfunction

  function automatic void add_token(kind_t k, logic [15:0] s, logic [7:0] len,
                                    logic [7:0] lead);
    rec_t r;
    if (char_tokens.size() >= MAX_RES) return;
    r.kind   = k;
    r.start  = s;
    r.length = len;
    r.lead   = lead;
    r.last   = 1'b0;
    char_tokens.push_back(r);
  endfunction

  function automatic void grow_len();
    if (lx_len < LEN_CAP) lx_len = lx_len + 8'd1;
  endfunction

  function automatic void open_token(mode_t m, logic [POS_BITS-1:0] pos, logic [7:0] c);
    lx_mode  = m;
    lx_start = pos;
    lx_len   = 8'h00;
    grow_len();
    lx_lead  = c;
  endfunction

  // Emit the open token, if any, and go idle
  function automatic void close_token();
    case (lx_mode)
      MODE_IDLE: ;
      MODE_IDENT:    add_token(KIND_IDENT, 16'(lx_start), lx_len, lx_lead);
      MODE_RESERVED: add_token(KIND_RESV, 16'(lx_start), lx_len, lx_lead);
      MODE_SYMWAIT:  add_token(KIND_SYMBOL, 16'(lx_start), 8'd1, lx_lead);
      default:       add_token(num_kind(lx_mode), 16'(lx_start), lx_len, lx_lead);
    endcase
    lx_mode = MODE_IDLE;
    lx_len  = 8'h00;
  endfunction

  // Lex a character with nothing open
  function automatic void start_token(logic [7:0] c, logic [POS_BITS-1:0] pos);
    if (is_space(c)) return;
    if (is_digit(c)) open_token(c == CH_ZERO ? MODE_ZERO : MODE_DIGIT, pos, c);
    else if (c == CH_BSL) open_token(MODE_RESERVED, pos, c);
    else if (is_alpha(c) || c == CH_UNDER) open_token(MODE_IDENT, pos, c);
    else begin
      case (c)
        CH_AMP, CH_STAR, CH_SLASH, CH_LT, CH_EQ, CH_GT, CH_BAR:
          open_token(MODE_SYMWAIT, pos, c);
        CH_BANG, CH_PCT, CH_PLUS, CH_COMMA, CH_MINUS, CH_SEMI, CH_CARET,
        CH_LBRC, CH_RBRC:
          add_token(KIND_SYMBOL, 16'(pos), 8'd1, c);
        default:
          add_token(KIND_BADSYM, 16'(pos), 8'd1, c);
      endcase
    end
  endfunction

  function automatic bit pairs_with(logic [7:0] lead, logic [7:0] c);
    case (lead)
      CH_AMP, CH_STAR, CH_SLASH, CH_BAR: return c == lead;
      CH_LT, CH_EQ, CH_GT:               return c == CH_EQ;
      default:                           return 1'b0;
    endcase
  endfunction

  // One accepted character: update state, queue up its tokens
  function automatic void lex_char(logic [7:0] c, logic eot);
    logic [POS_BITS-1:0] pos;
    mode_t               nxt;
    pos = lx_pos;
    char_tokens.delete();
    if (lx_mode == MODE_IDENT || lx_mode == MODE_RESERVED) begin
      if (is_alpha(c) || is_digit(c) || c == CH_UNDER) grow_len();
      else begin
        close_token();
        start_token(c, pos);
      end
    end else if (lx_mode == MODE_SYMWAIT) begin
      if (pairs_with(lx_lead, c)) begin
        add_token(KIND_SYMBOL, 16'(lx_start), 8'd2, lx_lead);
        lx_mode = MODE_IDLE;
        lx_len  = 8'h00;
      end else begin
        close_token();
        start_token(c, pos);
      end
    end else if (lx_mode != MODE_IDLE) begin
      nxt = next_num_mode(lx_mode, c);
      if (nxt != MODE_IDLE) begin
        lx_mode = nxt;
        grow_len();
      end else begin
        close_token();
        start_token(c, pos);
      end
    end else begin
      start_token(c, pos);
    end
    lx_pos = pos + 1'b1;

    // End of text: flush, end token, restart positions
    if (eot) begin
      close_token();
      add_token(KIND_END, 16'(lx_pos), 8'd0, 8'd0);
      lx_mode  = MODE_IDLE;
      lx_lead  = 8'h00;
      lx_start = '0;
      lx_len   = 8'h00;
      lx_pos   = '0;
    end

    if (char_tokens.size() > 0) char_tokens[char_tokens.size() - 1].last = 1'b1;
    foreach (char_tokens[i]) expected_tokens.push_back(char_tokens[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Token checker and predictor hook, sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_tokens
    rec_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("token %0d unexpected: kind %0d start %0d len %0d lead %02h last %0b",
                   tokens_seen, out_token_kind, out_token_start, out_token_length,
                   out_lead_char, out_last_of_run);
      end else begin
        want = expected_tokens.pop_front();
        if (out_token_kind !== want.kind || out_token_start !== want.start ||
            out_token_length !== want.length || out_lead_char !== want.lead ||
            out_last_of_run !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("token %0d expected: kind %0d start %0d len %0d lead %02h last %0b",
                     tokens_seen, want.kind, want.start, want.length, want.lead,
                     want.last);
            $display("token %0d actual:   kind %0d start %0d len %0d lead %02h last %0b",
                     tokens_seen, out_token_kind, out_token_start, out_token_length,
                     out_lead_char, out_last_of_run);
          end
        end
      end
      tokens_seen++;
    end
    if (rst_n && in_valid && in_ready === 1'b1) lex_char(in_char_code, in_end_of_text);
  end

  // Receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Cycle limit
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Offer one character and wait until it is taken; valid stays high after
  task automatic send_char(logic [7:0] c, logic eot);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_char_code   <= c;
    in_end_of_text <= eot;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  // Send the assembled text, end-of-text on its last character
  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_number_forms();
    add_str("0x1F 0B10 1.5e+3 6.2E9 42 0");
    send_text();
  endtask

  // Numbers stopping in a non-final state, and mixed-up digits
  task automatic test_bad_numbers();
    add_str("0x 0b 1e 1e- 3. 0b12 0xg");
    send_text();
  endtask

  // Identifiers, reserved words, all two-character symbols, lone symbols,
  // a symbol lead left waiting at end of text
  task automatic test_words_and_symbols();
    add_str("x_9 \\if a&&b**c//d<=e==f>=g||h<i !%+,-;^{}*");
    send_text();
  endtask

  // Null, high bytes, unknown symbols, whitespace, then a blank text
  task automatic test_odd_bytes();
    text_q = '{8'h00, CH_DOT, "#", 8'h80, 8'hFF, 8'h09, 8'h0D, 8'h7F};
    send_text();
    add_str(" ");
    send_text();
  endtask

  // Requests and results back to back: no idling on either side
  task automatic test_back_to_back();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    add_str("ab+12 0x3f<=c||d");
    send_text();
    tx_idle_pct = 12;
    rx_idle_pct = 12;
  endtask

  // Receiver holds off while the sender keeps offering token-heavy text
  task automatic test_input_stall();
    hold_asked++;
    repeat (4) add_str("a+");
    add_str("b");
    send_text();
  endtask

  // Random texts: mostly well-formed tokens, some glued, some noise
  task automatic test_random_texts();
    int sent;
    sent = 0;
    while (sent < RANDOM_CHARS) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(8, 1)) text_q.push_back(8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(6, 1)) begin
          case ($urandom_range(10))
            0: repeat ($urandom_range(4, 1)) text_q.push_back(pick("0123456789"));
            1: begin
              add_str("0");
              text_q.push_back(pick("xX"));
              repeat ($urandom_range(3, 1)) text_q.push_back(pick("0123456789abcdefABCDEF"));
            end
            2: begin
              add_str("0");
              text_q.push_back(pick("bB"));
              repeat ($urandom_range(4, 1)) text_q.push_back(pick("01"));
            end
            3: begin
              text_q.push_back(pick("0123456789"));
              add_str(".");
              repeat ($urandom_range(2, 1)) text_q.push_back(pick("0123456789"));
              if ($urandom_range(1)) begin
                text_q.push_back(pick("eE"));
                if ($urandom_range(1)) text_q.push_back(pick("+-"));
                repeat ($urandom_range(2, 1)) text_q.push_back(pick("0123456789"));
              end
            end
            4: begin
              case ($urandom_range(5))
                0: add_str("0x");
                1: add_str("0b");
                2: add_str("7e");
                3: add_str("7e+");
                4: add_str("7E-");
                default: add_str("3.");
              endcase
            end
            5: begin
              text_q.push_back(pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_"));
              repeat ($urandom_range(4)) text_q.push_back(pick("aZqB_09xe7"));
            end
            6: begin
              add_str("\\");
              repeat ($urandom_range(3)) text_q.push_back(pick("kwZ_5"));
            end
            7: begin
              case ($urandom_range(6))
                0: add_str("&&");
                1: add_str("**");
                2: add_str("//");
                3: add_str("<=");
                4: add_str("==");
                5: add_str(">=");
                default: add_str("||");
              endcase
            end
            8: text_q.push_back(pick("&*/<=>|!%+,-;^{}"));
            9: text_q.push_back(8'($urandom_range(255)));
            default: text_q.push_back(pick("#.$@()?~:'\"`[]"));
          endcase
          // separator: often none so tokens butt against each other
          case ($urandom_range(9))
            5, 6, 7, 8: text_q.push_back(CH_SPACE);
            9:          text_q.push_back(8'($urandom_range(13, 9)));
            default: ;
          endcase
        end
      end
      foreach (text_q[i]) if (!is_space(text_q[i])) sent++;
      send_text();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_number_forms();
    test_bad_numbers();
    test_words_and_symbols();
    test_odd_bytes();
    test_back_to_back();
    test_input_stall();
    test_random_texts();

    // drain: all tokens out, then a few quiet cycles
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_tokens.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
